>>> rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// Bounded sequential list package
// Shared widths, command and status codes, and the queued command word.
// ----------------------------------------------------------------------------
package bsl_pkg;

  localparam int unsigned CAPACITY_DEFAULT = 16;
  localparam int unsigned QUEUE_DEPTH      = 2;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIDX_W   = 4;
  localparam int unsigned ECNT_W   = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6,
    OP_READ       = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_FULL      = 3'd1,
    STS_EMPTY     = 3'd2,
    STS_BAD_POS   = 3'd3,
    STS_NOT_FOUND = 3'd4
  } status_e;

  typedef struct packed {
    op_e                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

>>> rtl/bsl_front.sv
// ----------------------------------------------------------------------------
// Bounded sequential list front end
// Accepts input words, decodes the command and hands them to the queue.
// ----------------------------------------------------------------------------
module bsl_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [bsl_pkg::CMD_W-1:0]      cmd_i,
  input  logic [bsl_pkg::POS_W-1:0]      position_i,
  input  logic signed [bsl_pkg::VAL_W-1:0] item_value_i,
  output logic                           push_valid_o,
  input  logic                           push_ready_i,
  output bsl_pkg::cmd_t                  push_word_o
);
  import bsl_pkg::*;

  logic valid_q, valid_d;
  cmd_t word_q, word_d;
  logic in_fire;

  assign in_ready_o = !valid_q || push_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    word_d  = word_q;
    if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_fire) begin
      valid_d         = 1'b1;
      word_d.op       = op_e'(cmd_i);
      word_d.position = position_i;
      word_d.value    = item_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign push_valid_o = valid_q;
  assign push_word_o  = word_q;

endmodule

>>> rtl/bsl_fifo.sv
// ----------------------------------------------------------------------------
// Bounded sequential list command queue
// Short queue of decoded command words between front end and back end.
// ----------------------------------------------------------------------------
module bsl_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  bsl_pkg::cmd_t push_word_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output bsl_pkg::cmd_t pop_word_o
);
  import bsl_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [LVL_W-1:0] level_q, level_d;
  logic             push_fire, pop_fire;

  assign push_ready_o = (level_q != LVL_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign pop_word_o   = slot_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (push_fire) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_fire) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_fire && !pop_fire) begin
      level_d = level_q + 1'b1;
    end else if (pop_fire && !push_fire) begin
      level_d = level_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      slot_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

>>> rtl/bsl_back.sv
// ----------------------------------------------------------------------------
// Bounded sequential list back end
// Holds the entry memory and count, runs each command as a short sequence
// of memory moves, and registers the result word.
// ----------------------------------------------------------------------------
module bsl_back #(
  parameter int unsigned CAPACITY = bsl_pkg::CAPACITY_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  output logic                             q_ready_o,
  input  bsl_pkg::cmd_t                    q_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bsl_pkg::STATUS_W-1:0]     status_o,
  output logic [bsl_pkg::FIDX_W-1:0]       found_index_o,
  output logic signed [bsl_pkg::VAL_W-1:0] read_value_o,
  output logic [bsl_pkg::ECNT_W-1:0]       entry_count_o
);
  import bsl_pkg::*;

  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_UP_RD    = 9'b000000010,
    ST_UP_WR    = 9'b000000100,
    ST_DN_RD    = 9'b000001000,
    ST_DN_WR    = 9'b000010000,
    ST_SCAN     = 9'b000100000,
    ST_SCAN_CMP = 9'b001000000,
    ST_RD_WAIT  = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  state_e                  state_q, state_d;
  cmd_t                    cmd_q, cmd_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           tgt_q, tgt_d;
  status_e                 sts_q, sts_d;
  logic [FIDX_W-1:0]       fidx_q, fidx_d;
  logic signed [VAL_W-1:0] rval_q, rval_d;

  logic                    out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]     out_sts_q, out_sts_d;
  logic [FIDX_W-1:0]       out_fidx_q, out_fidx_d;
  logic signed [VAL_W-1:0] out_rval_q, out_rval_d;
  logic [ECNT_W-1:0]       out_cnt_q, out_cnt_d;

  logic signed [VAL_W-1:0] mem [CAPACITY];
  logic signed [VAL_W-1:0] mem_rdata_q;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [AW-1:0]           mem_raddr;
  logic signed [VAL_W-1:0] mem_wdata;

  logic [CW-1:0]           idx_m1, idx_p1;
  logic [CMPW-1:0]         pos_x, cnt_x;
  logic                    full;

  assign idx_m1    = idx_q - 1'b1;
  assign idx_p1    = idx_q + 1'b1;
  assign pos_x     = CMPW'(q_word_i.position);
  assign cnt_x     = CMPW'(cnt_q);
  assign full      = (cnt_q >= CW'(CAPACITY));
  assign q_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    sts_d       = sts_q;
    fidx_d      = fidx_q;
    rval_d      = rval_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[AW-1:0];
    mem_wdata   = mem_rdata_q;
    mem_raddr   = idx_q[AW-1:0];
    out_valid_d = out_valid_q && !out_ready_i;
    out_sts_d   = out_sts_q;
    out_fidx_d  = out_fidx_q;
    out_rval_d  = out_rval_q;
    out_cnt_d   = out_cnt_q;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          cmd_d   = q_word_i;
          sts_d   = STS_OK;
          fidx_d  = '0;
          rval_d  = '0;
          state_d = ST_DONE;
          case (q_word_i.op)
            OP_PUSH_BACK: begin
              if (full) begin
                sts_d = STS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = cnt_q[AW-1:0];
                mem_wdata = q_word_i.value;
                cnt_d     = cnt_q + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                sts_d = STS_FULL;
              end else begin
                idx_d   = cnt_q;
                tgt_d   = '0;
                state_d = ST_UP_RD;
              end
            end
            OP_POP_BACK: begin
              if (cnt_q == '0) begin
                sts_d = STS_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (cnt_q == '0) begin
                sts_d = STS_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = ST_DN_RD;
              end
            end
            OP_INSERT: begin
              if (pos_x > cnt_x) begin
                sts_d = STS_BAD_POS;
              end else if (full) begin
                sts_d = STS_FULL;
              end else begin
                idx_d   = cnt_q;
                tgt_d   = CW'(q_word_i.position);
                state_d = ST_UP_RD;
              end
            end
            OP_ERASE: begin
              if (pos_x >= cnt_x) begin
                sts_d = STS_BAD_POS;
              end else begin
                idx_d   = CW'(q_word_i.position);
                state_d = ST_DN_RD;
              end
            end
            OP_FIND: begin
              idx_d   = '0;
              state_d = ST_SCAN;
            end
            OP_READ: begin
              if (pos_x >= cnt_x) begin
                sts_d = STS_BAD_POS;
              end else begin
                mem_raddr = AW'(q_word_i.position);
                state_d   = ST_RD_WAIT;
              end
            end
            default: begin
              sts_d = STS_OK;
            end
          endcase
        end
      end
      ST_UP_RD: begin
        if (idx_q == tgt_q) begin
          mem_we    = 1'b1;
          mem_waddr = tgt_q[AW-1:0];
          mem_wdata = cmd_q.value;
          cnt_d     = cnt_q + 1'b1;
          state_d   = ST_DONE;
        end else begin
          mem_raddr = idx_m1[AW-1:0];
          state_d   = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        idx_d     = idx_m1;
        state_d   = ST_UP_RD;
      end
      ST_DN_RD: begin
        if (idx_p1 >= cnt_q) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = ST_DONE;
        end else begin
          mem_raddr = idx_p1[AW-1:0];
          state_d   = ST_DN_WR;
        end
      end
      ST_DN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        idx_d     = idx_p1;
        state_d   = ST_DN_RD;
      end
      ST_SCAN: begin
        if (idx_q >= cnt_q) begin
          sts_d   = STS_NOT_FOUND;
          state_d = ST_DONE;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (mem_rdata_q == cmd_q.value) begin
          fidx_d  = FIDX_W'(idx_q);
          state_d = ST_DONE;
        end else begin
          idx_d   = idx_p1;
          state_d = ST_SCAN;
        end
      end
      ST_RD_WAIT: begin
        rval_d  = mem_rdata_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sts_d   = sts_q;
          out_fidx_d  = fidx_q;
          out_rval_d  = rval_q;
          out_cnt_d   = ECNT_W'(cnt_q);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    tgt_q      <= tgt_d;
    sts_q      <= sts_d;
    fidx_q     <= fidx_d;
    rval_q     <= rval_d;
    out_sts_q  <= out_sts_d;
    out_fidx_q <= out_fidx_d;
    out_rval_q <= out_rval_d;
    out_cnt_q  <= out_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_sts_q;
  assign found_index_o = out_fidx_q;
  assign read_value_o  = out_rval_q;
  assign entry_count_o = out_cnt_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (CW'(mem_waddr) < CW'(CAPACITY)))
    else $error("memory write beyond capacity");

  a_done_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !mem_we)
    else $error("memory write while result pending");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && (!out_valid_q || out_ready_i))
      |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not registered on completion");
`endif

endmodule

>>> rtl/bounded_sequential_list.sv
// ----------------------------------------------------------------------------
// Bounded sequential list
// Ordered list of up to CAPACITY signed 32-bit entries with push, pop,
// insert, erase, find and read commands, one result word per command.
// ----------------------------------------------------------------------------
// A command word passes a one-word input register and a two-word queue, then
// runs in the back end against an entry memory with one write and one
// registered read per cycle. Push back, pop back and refused commands go
// from idle straight to done; read passes a wait state for the memory read.
// Every entry moved by push front, insert, erase or pop front costs a read
// state, then a write state. Find compares one entry per scan and compare
// state pair, up to count entries. The result register frees the back end to
// start the next command while a result waits.
module bounded_sequential_list #(
  parameter int unsigned CAPACITY = bsl_pkg::CAPACITY_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bsl_pkg::CMD_W-1:0]        cmd_i,
  input  logic [bsl_pkg::POS_W-1:0]        position_i,
  input  logic signed [bsl_pkg::VAL_W-1:0] item_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bsl_pkg::STATUS_W-1:0]     status_o,
  output logic [bsl_pkg::FIDX_W-1:0]       found_index_o,
  output logic signed [bsl_pkg::VAL_W-1:0] read_value_o,
  output logic [bsl_pkg::ECNT_W-1:0]       entry_count_o
);
  import bsl_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_word;
  logic pop_valid, pop_ready;
  cmd_t pop_word;

  bsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_word_o  (push_word)
  );

  bsl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_word_i  (push_word),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_word_o   (pop_word)
  );

  bsl_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (pop_valid),
    .q_ready_o     (pop_ready),
    .q_word_i      (pop_word),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

endmodule

>>> tb/bounded_sequential_list_test.sv
// ----------------------------------------------------------------------------
// Bounded sequential list testbench
// Feeds the list a short table of edge-case commands and then about 1400
// random ones that drift between an empty and a full list. Each result word
// is checked field by field against a software copy of the list or the
// fixed result of its table row. Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bounded_sequential_list_test;
  import bsl_pkg::*;

  localparam int unsigned LIST_CAP   = CAPACITY_DEFAULT;
  localparam int          RAND_ITEMS = 1400;
  localparam int          TAIL_CYC   = 64;
  localparam int          CYCLE_MAX  = 600000;
  localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] V_MIN = 32'sh80000000;

  typedef struct packed {
    status_e                 status;
    logic [FIDX_W-1:0]       fidx;
    logic signed [VAL_W-1:0] rval;
    logic [ECNT_W-1:0]       cnt;
  } list_result_t;

  typedef struct {
    bit           fixed;
    list_result_t res;
  } word_tag_t;

  typedef struct {
    op_e                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      reps;
    bit                      fixed;
    list_result_t            res;
  } dir_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [CMD_W-1:0]        cmd_i = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic signed [VAL_W-1:0] item_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [STATUS_W-1:0]     status_o;
  logic [FIDX_W-1:0]       found_index_o;
  logic signed [VAL_W-1:0] read_value_o;
  logic [ECNT_W-1:0]       entry_count_o;

  bounded_sequential_list dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .position_i    (position_i),
    .item_value_i  (item_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .found_index_o (found_index_o),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic signed [VAL_W-1:0] list_mem [LIST_CAP];
  int unsigned             list_cnt = 0;
  list_result_t            result_q [$];
  word_tag_t               tag_q [$];
  int                      err_cnt = 0;
  int                      cycle_cnt = 0;
  int                      word_cnt = 0;
  int                      result_cnt = 0;
  int                      cmd_seen [8];
  int                      status_seen [8];
  int                      send_burst = 0;
  int                      recv_burst = 0;

  task automatic apply_list_cmd(input op_e op, input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val,
                                output list_result_t res);
    int k;
    res.status = STS_OK;
    res.fidx   = '0;
    res.rval   = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (list_cnt >= LIST_CAP) begin
          res.status = STS_FULL;
        end else begin
          list_mem[list_cnt] = val;
          list_cnt++;
        end
      end
      OP_PUSH_FRONT: begin
        if (list_cnt >= LIST_CAP) begin
          res.status = STS_FULL;
        end else begin
          for (k = list_cnt; k > 0; k--) list_mem[k] = list_mem[k-1];
          list_mem[0] = val;
          list_cnt++;
        end
      end
      OP_POP_BACK: begin
        if (list_cnt == 0) res.status = STS_EMPTY;
        else list_cnt--;
      end
      OP_POP_FRONT: begin
        if (list_cnt == 0) begin
          res.status = STS_EMPTY;
        end else begin
          for (k = 0; k + 1 < list_cnt; k++) list_mem[k] = list_mem[k+1];
          list_cnt--;
        end
      end
      OP_INSERT: begin
        if (pos > list_cnt) begin
          res.status = STS_BAD_POS;
        end else if (list_cnt >= LIST_CAP) begin
          res.status = STS_FULL;
        end else begin
          for (k = list_cnt; k > pos; k--) list_mem[k] = list_mem[k-1];
          list_mem[pos] = val;
          list_cnt++;
        end
      end
      OP_ERASE: begin
        if (pos >= list_cnt) begin
          res.status = STS_BAD_POS;
        end else begin
          for (k = pos; k + 1 < list_cnt; k++) list_mem[k] = list_mem[k+1];
          list_cnt--;
        end
      end
      OP_FIND: begin
        res.status = STS_NOT_FOUND;
        for (k = 0; k < list_cnt; k++) begin
          if (res.status == STS_NOT_FOUND && list_mem[k] == val) begin
            res.status = STS_OK;
            res.fidx   = k[FIDX_W-1:0];
          end
        end
      end
      default: begin
        if (pos >= list_cnt) res.status = STS_BAD_POS;
        else res.rval = list_mem[pos];
      end
    endcase
    res.cnt = list_cnt[ECNT_W-1:0];
  endtask

  function automatic dir_row_t mk_row(op_e op, logic [POS_W-1:0] pos,
                                      logic signed [VAL_W-1:0] val, int reps);
    dir_row_t r;
    r.op    = op;
    r.pos   = pos;
    r.val   = val;
    r.reps  = reps;
    r.fixed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic dir_row_t mk_fixed(op_e op, logic [POS_W-1:0] pos,
                                        logic signed [VAL_W-1:0] val, status_e st,
                                        logic [FIDX_W-1:0] fidx,
                                        logic signed [VAL_W-1:0] rval,
                                        logic [ECNT_W-1:0] cnt);
    dir_row_t r;
    r.op         = op;
    r.pos        = pos;
    r.val        = val;
    r.reps       = 1;
    r.fixed      = 1'b1;
    r.res.status = st;
    r.res.fidx   = fidx;
    r.res.rval   = rval;
    r.res.cnt    = cnt;
    return r;
  endfunction

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) burst = $urandom_range(10, 40);
    return $urandom_range(0, 15);
  endfunction

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    err_cnt++;
    if (err_cnt <= 10)
      $display("mismatch on result %0d, %s: expected %h, got %h",
               result_cnt, field, exp_v, act_v);
  endtask

  task automatic send_word(input op_e op, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val, input bit fixed,
                           input list_result_t res);
    int        gap;
    word_tag_t tag;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_i        <= op;
    position_i   <= pos;
    item_value_i <= val;
    in_valid_i   <= 1'b1;
    tag.fixed = fixed;
    tag.res   = res;
    tag_q.push_back(tag);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0 || tag_q.size() != 0) @(posedge clk_i);
  endtask

  list_result_t mon_pred;
  list_result_t mon_exp;
  word_tag_t    mon_tag;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        mon_tag = tag_q.pop_front();
        apply_list_cmd(op_e'(cmd_i), position_i, item_value_i, mon_pred);
        result_q.push_back(mon_tag.fixed ? mon_tag.res : mon_pred);
        cmd_seen[cmd_i]++;
        word_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result word: status %0d count %0d",
                     status_o, entry_count_o);
        end else begin
          mon_exp = result_q.pop_front();
          if (status_o !== mon_exp.status)
            note_mismatch("status", 32'(mon_exp.status), 32'(status_o));
          if (found_index_o !== mon_exp.fidx)
            note_mismatch("found_index", 32'(mon_exp.fidx), 32'(found_index_o));
          if (read_value_o !== mon_exp.rval)
            note_mismatch("read_value", mon_exp.rval, read_value_o);
          if (entry_count_o !== mon_exp.cnt)
            note_mismatch("entry_count", 32'(mon_exp.cnt), 32'(entry_count_o));
          status_seen[mon_exp.status]++;
          result_cnt++;
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_MAX);
    $display("timeout after %0d cycles", cycle_cnt);
    $display("status: fail");
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait(recv_burst);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  dir_row_t dir_tab [25];

  initial begin
    int                      i;
    int                      j;
    int                      r;
    int                      fill_target;
    bit                      grow;
    op_e                     op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    op_e                     grow_ops [3];
    op_e                     shrink_ops [3];
    grow_ops   = '{OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT};
    shrink_ops = '{OP_POP_BACK, OP_POP_FRONT, OP_ERASE};
    dir_tab = '{
      mk_fixed(OP_POP_BACK,    0,  0,     STS_EMPTY,     0, 0,     0),
      mk_fixed(OP_POP_FRONT,   0,  0,     STS_EMPTY,     0, 0,     0),
      mk_fixed(OP_ERASE,       0,  0,     STS_BAD_POS,   0, 0,     0),
      mk_fixed(OP_READ,        0,  0,     STS_BAD_POS,   0, 0,     0),
      mk_fixed(OP_FIND,        0,  0,     STS_NOT_FOUND, 0, 0,     0),
      mk_fixed(OP_INSERT,      1,  5,     STS_BAD_POS,   0, 0,     0),
      mk_fixed(OP_INSERT,      0,  -1,    STS_OK,        0, 0,     1),
      mk_fixed(OP_PUSH_BACK,   0,  V_MAX, STS_OK,        0, 0,     2),
      mk_fixed(OP_PUSH_FRONT,  31, V_MIN, STS_OK,        0, 0,     3),
      mk_fixed(OP_READ,        0,  0,     STS_OK,        0, V_MIN, 3),
      mk_fixed(OP_FIND,        0,  V_MAX, STS_OK,        2, 0,     3),
      mk_row(OP_PUSH_BACK,     0,  32'sh12345678, 12),
      mk_fixed(OP_PUSH_BACK,   0,  -1,    STS_OK,        0, 0,     16),
      mk_fixed(OP_FIND,        0,  -1,    STS_OK,        1, 0,     16),
      mk_fixed(OP_PUSH_BACK,   0,  7,     STS_FULL,      0, 0,     16),
      mk_fixed(OP_PUSH_FRONT,  0,  7,     STS_FULL,      0, 0,     16),
      mk_fixed(OP_INSERT,      16, 7,     STS_FULL,      0, 0,     16),
      mk_fixed(OP_INSERT,      17, 7,     STS_BAD_POS,   0, 0,     16),
      mk_fixed(OP_READ,        16, 0,     STS_BAD_POS,   0, 0,     16),
      mk_fixed(OP_READ,        15, 0,     STS_OK,        0, -1,    16),
      mk_fixed(OP_ERASE,       15, 0,     STS_OK,        0, 0,     15),
      mk_row(OP_INSERT,        3,  32'sh5a5a5a5a, 1),
      mk_row(OP_POP_FRONT,     0,  0,     1),
      mk_row(OP_ERASE,         0,  0,     1),
      mk_row(OP_READ,          2,  0,     1)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      for (j = 0; j < dir_tab[i].reps; j++)
        send_word(dir_tab[i].op, dir_tab[i].pos, dir_tab[i].val + j,
                  dir_tab[i].fixed, dir_tab[i].res);
    end
    drain_results();

    fill_target = LIST_CAP;
    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 3))
          0:       fill_target = 0;
          1:       fill_target = LIST_CAP;
          default: fill_target = $urandom_range(0, LIST_CAP);
        endcase
      end
      if (i > 0 && i % 350 == 0) drain_results();
      if ($urandom_range(0, 19) == 0) begin
        op  = op_e'($urandom_range(0, 7));
        pos = POS_W'($urandom_range(0, 31));
        val = $urandom;
      end else begin
        grow = (list_cnt < fill_target);
        r = $urandom_range(0, 99);
        if (r < 50)
          op = grow ? grow_ops[$urandom_range(0, 2)] : shrink_ops[$urandom_range(0, 2)];
        else if (r < 65)
          op = grow ? shrink_ops[$urandom_range(0, 2)] : grow_ops[$urandom_range(0, 2)];
        else
          op = ($urandom_range(0, 1) == 0) ? OP_FIND : OP_READ;
        if ($urandom_range(0, 4) == 0) pos = POS_W'($urandom_range(0, 31));
        else pos = POS_W'($urandom_range(0, list_cnt));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: val = $urandom_range(0, 7) - 3;
          4:          val = V_MAX;
          5:          val = V_MIN;
          default:    val = $urandom;
        endcase
      end
      send_word(op, pos, val, 1'b0, '0);
    end

    drain_results();
    repeat (TAIL_CYC) @(posedge clk_i);

    $write("ran %0d command words, checked %0d results: ", word_cnt, result_cnt);
    $display("full %0d, empty %0d, bad position %0d, not found %0d",
             status_seen[STS_FULL], status_seen[STS_EMPTY],
             status_seen[STS_BAD_POS], status_seen[STS_NOT_FOUND]);
    $write("per command: push_back %0d push_front %0d pop_back %0d pop_front %0d ",
           cmd_seen[OP_PUSH_BACK], cmd_seen[OP_PUSH_FRONT], cmd_seen[OP_POP_BACK],
           cmd_seen[OP_POP_FRONT]);
    $display("insert %0d erase %0d find %0d read %0d",
             cmd_seen[OP_INSERT], cmd_seen[OP_ERASE],
             cmd_seen[OP_FIND], cmd_seen[OP_READ]);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bsl_pkg.sv
rtl/bsl_front.sv
rtl/bsl_fifo.sv
rtl/bsl_back.sv
rtl/bounded_sequential_list.sv
tb/bounded_sequential_list_test.sv
